// ===== src/vrra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_pkg: shared types for the variable record ring allocator
// Command and status codes, beat payloads, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package vrra_pkg;

    // Fixed field widths
    localparam int POS_W  = 13;
    localparam int LEN_W  = 13;
    localparam int OFF_W  = 12;
    localparam int CNT_W  = 10;
    localparam int HDR_W  = 13;
    // Divider operand width: covers a length plus header plus alignment slack
    localparam int DIV_W  = 14;
    // Record header size in bytes
    localparam int HEADER = 8;

    typedef enum logic [1:0] {
        CMD_RESERVE = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_NO_ROOM = 3'd1,
        STS_BAD_LEN = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_NOT_RSV = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t               command;
        logic [LEN_W-1:0]   length;
    } in_beat_t;

    typedef struct packed {
        status_t            status;
        logic [OFF_W-1:0]   offset;
        logic [LEN_W-1:0]   rec_length;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RSV_NEED,
        ST_RSV_CHK,
        ST_RSV_WR0,
        ST_CMT_RD,
        ST_CMT_FP,
        ST_CMT_NEED,
        ST_CMT_UPD,
        ST_RD_RP,
        ST_MARK,
        ST_RD_ZERO,
        ST_LAT_ZERO,
        ST_REC_NEED,
        ST_REC_UPD,
        ST_RESP
    } state_t;

    // Operand of the shared divide-by-ALIGN unit
    typedef enum logic [1:0] {
        DIV_T_LEN,
        DIV_T_HDR,
        DIV_WP,
        DIV_RP
    } div_src_t;

    // Outcome of the reserve room check
    typedef enum logic [1:0] {
        RO_BAD,
        RO_NO_ROOM,
        RO_HERE,
        RO_WRAP
    } rsv_out_t;

    typedef struct packed {
        logic       load;
        div_src_t   div_src;
        logic       need_ld;
        logic       rd_en;
        logic       rd_zero;
        logic       hdr_ld;
        logic       rsv_here;
        logic       rsv_wrap;
        logic       rsv_wr0;
        logic       fail;
        status_t    fail_code;
        logic       rsv_clr;
        logic       rp_zero;
        logic       wp_adv;
        logic       rec_rep;
        logic       rp_adv;
        logic       out_ld;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       rsv;
        logic       empty;
        rsv_out_t   rsv_out;
        logic       marker;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== src/vrra_adiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_adiv: registered divide by ALIGN
// Multiplies by a rounded-up reciprocal and shifts; exact for every operand
// of DIV_W bits. The result is held in a register.
// ----------------------------------------------------------------------------
module vrra_adiv #(
    parameter int ALIGN = 8
) (
    input  logic                         aclk,
    input  logic [vrra_pkg::DIV_W-1:0]   n,
    output logic [vrra_pkg::DIV_W-1:0]   q
);

    localparam int SH    = vrra_pkg::DIV_W + $clog2(ALIGN) + 1;
    localparam int PW    = vrra_pkg::DIV_W + SH + 1;
    localparam longint RECIP = ((longint'(1) << SH) + ALIGN - 1) / ALIGN;

    logic [PW-1:0]              prod;
    logic [vrra_pkg::DIV_W-1:0] q_reg;

    // reciprocal multiply, quotient in the upper bits
    assign prod = PW'(n) * PW'(RECIP);

    always_ff @(posedge aclk) begin
        q_reg <= vrra_pkg::DIV_W'(prod >> SH);
    end

    assign q = q_reg;

endmodule

// ===== src/vrra_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_dp: allocator datapath
// Ring pointers, record count, pending reservation, header memory, footprint
// arithmetic, room checks and the result and output registers.
// ----------------------------------------------------------------------------
module vrra_dp #(
    parameter int CAPACITY = 4096,
    parameter int ALIGN    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vrra_pkg::in_beat_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vrra_pkg::out_beat_t   m_data,
    input  vrra_pkg::dp_cmd_t     cmd,
    output vrra_pkg::dp_stat_t    stat
);

    localparam int SLOTS = (CAPACITY + ALIGN - 1) / ALIGN;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CAPW  = $clog2(CAPACITY + 1);
    localparam int CW    = (CAPW > vrra_pkg::DIV_W) ? CAPW + 1 : vrra_pkg::DIV_W + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] HDR_C = CW'(vrra_pkg::HEADER);
    localparam logic [vrra_pkg::DIV_W-1:0] T_ADD =
        vrra_pkg::DIV_W'(vrra_pkg::HEADER + ALIGN - 1);

    // state
    vrra_pkg::cmd_t                 cmd_reg;
    logic [vrra_pkg::LEN_W-1:0]     len_reg;
    logic [vrra_pkg::POS_W-1:0]     wp_reg;
    logic [vrra_pkg::POS_W-1:0]     rp_reg;
    logic [vrra_pkg::CNT_W-1:0]     cnt_reg;
    logic                           rsv_reg;
    logic [vrra_pkg::DIV_W-1:0]     need_reg;
    logic [vrra_pkg::HDR_W-1:0]     hdr_reg;
    logic [vrra_pkg::HDR_W-1:0]     rd_data_reg;
    logic                           rd_ok_reg;
    vrra_pkg::out_beat_t            res_reg;
    vrra_pkg::out_beat_t            res_next;
    logic                           m_valid_reg;
    vrra_pkg::out_beat_t            m_data_reg;

    logic [vrra_pkg::HDR_W-1:0]     hdr_mem [SLOTS];

    logic [vrra_pkg::DIV_W-1:0]     div_n;
    logic [vrra_pkg::DIV_W-1:0]     q;
    logic                           q_in_range;
    logic [IW-1:0]                  q_idx;
    logic [vrra_pkg::HDR_W-1:0]     hdr_now;
    logic [CW-1:0]                  wp_w;
    logic [CW-1:0]                  rp_w;
    logic [CW-1:0]                  need_w;
    logic [CW-1:0]                  len_w;
    logic                           bad_len;
    logic                           full;
    logic                           mark_room;
    vrra_pkg::rsv_out_t             rsv_out;
    logic                           wr_en;
    logic [IW-1:0]                  wr_addr;
    logic [vrra_pkg::HDR_W-1:0]     wr_data;
    logic [IW-1:0]                  rd_addr;
    logic                           rd_ok;

    // header as read; a slot past the store reads as zero
    assign hdr_now = rd_ok_reg ? rd_data_reg : '0;

    // shared divide-by-ALIGN: footprint quotient or slot index
    always_comb begin
        case (cmd.div_src)
            vrra_pkg::DIV_T_LEN: div_n = vrra_pkg::DIV_W'(len_reg) + T_ADD;
            vrra_pkg::DIV_T_HDR: div_n = vrra_pkg::DIV_W'(hdr_now) + T_ADD;
            vrra_pkg::DIV_WP:    div_n = vrra_pkg::DIV_W'(wp_reg);
            default:             div_n = vrra_pkg::DIV_W'(rp_reg);
        endcase
    end

    vrra_adiv #(
        .ALIGN (ALIGN)
    ) u_div (
        .aclk (aclk),
        .n    (div_n),
        .q    (q)
    );

    assign q_in_range = (32'(q) < 32'(SLOTS));
    assign q_idx      = IW'(q);

    // reserve room check
    assign wp_w      = CW'(wp_reg);
    assign rp_w      = CW'(rp_reg);
    assign need_w    = CW'(need_reg);
    assign len_w     = CW'(len_reg);
    assign bad_len   = (len_reg == '0) || (len_w > CAP_C);
    assign full      = (wp_reg == rp_reg) && (cnt_reg != '0);
    assign mark_room = (wp_w <= CAP_C) && ((CAP_C - wp_w) >= HDR_C);

    always_comb begin
        if (bad_len) begin
            rsv_out = vrra_pkg::RO_BAD;
        end else if (full) begin
            rsv_out = vrra_pkg::RO_NO_ROOM;
        end else if (wp_reg < rp_reg) begin
            rsv_out = ((rp_w - wp_w) < need_w) ? vrra_pkg::RO_NO_ROOM : vrra_pkg::RO_HERE;
        end else if ((wp_w > CAP_C) || ((CAP_C - wp_w) < need_w)) begin
            rsv_out = (rp_w < need_w) ? vrra_pkg::RO_NO_ROOM : vrra_pkg::RO_WRAP;
        end else begin
            rsv_out = vrra_pkg::RO_HERE;
        end
    end

    // status to the controller
    always_comb begin
        stat.cmd      = cmd_reg;
        stat.rsv      = rsv_reg;
        stat.empty    = (cnt_reg == '0);
        stat.rsv_out  = rsv_out;
        stat.marker   = (rp_w > CAP_C) || ((CAP_C - rp_w) < HDR_C) || (hdr_now == '0);
        stat.out_free = !m_valid_reg || m_ready;
    end

    // header memory ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = q_idx;
        wr_data = len_reg;
        if (cmd.rsv_here) begin
            wr_en = q_in_range;
        end else if (cmd.rsv_wrap) begin
            wr_en   = q_in_range && mark_room;
            wr_data = '0;
        end else if (cmd.rsv_wr0) begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end
    end

    assign rd_addr = cmd.rd_zero ? '0 : q_idx;
    assign rd_ok   = cmd.rd_zero | q_in_range;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= hdr_mem[rd_addr];
            rd_ok_reg   <= rd_ok;
        end
    end

    // result of the current command
    always_comb begin
        res_next = res_reg;
        if (cmd.fail) begin
            res_next.status     = cmd.fail_code;
            res_next.offset     = '0;
            res_next.rec_length = '0;
        end else if (cmd.rsv_here) begin
            res_next.status     = vrra_pkg::STS_OK;
            res_next.offset     = vrra_pkg::OFF_W'(wp_reg) +
                                  vrra_pkg::OFF_W'(vrra_pkg::HEADER);
            res_next.rec_length = len_reg;
        end else if (cmd.rsv_wr0) begin
            res_next.status     = vrra_pkg::STS_OK;
            res_next.offset     = vrra_pkg::OFF_W'(vrra_pkg::HEADER);
            res_next.rec_length = len_reg;
        end else if (cmd.wp_adv) begin
            res_next.status     = vrra_pkg::STS_OK;
            res_next.offset     = vrra_pkg::OFF_W'(wp_reg) +
                                  vrra_pkg::OFF_W'(vrra_pkg::HEADER);
            res_next.rec_length = hdr_reg;
        end else if (cmd.rec_rep) begin
            res_next.status     = vrra_pkg::STS_OK;
            res_next.offset     = vrra_pkg::OFF_W'(rp_reg) +
                                  vrra_pkg::OFF_W'(vrra_pkg::HEADER);
            res_next.rec_length = hdr_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_data.command;
            len_reg <= s_data.length;
        end
        if (cmd.need_ld) begin
            need_reg <= vrra_pkg::DIV_W'(q * vrra_pkg::DIV_W'(ALIGN));
        end
        if (cmd.hdr_ld) begin
            hdr_reg <= hdr_now;
        end
        res_reg <= res_next;
        if (cmd.out_ld) begin
            m_data_reg <= res_reg;
        end
    end

    // pointers, count, reservation and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            cnt_reg     <= '0;
            rsv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.rsv_here || cmd.rsv_wr0) begin
                rsv_reg <= 1'b1;
            end
            if (cmd.rsv_clr) begin
                rsv_reg <= 1'b0;
            end
            if (cmd.rsv_wrap) begin
                wp_reg <= '0;
            end
            if (cmd.wp_adv) begin
                wp_reg  <= wp_reg + vrra_pkg::POS_W'(need_reg);
                cnt_reg <= cnt_reg + 1'b1;
                rsv_reg <= 1'b0;
            end
            if (cmd.rp_zero) begin
                rp_reg <= '0;
            end
            if (cmd.rp_adv) begin
                rp_reg  <= rp_reg + vrra_pkg::POS_W'(need_reg);
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/vrra_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_ctrl: allocator sequencer
// Walks each command through divide, header read/write, update and response
// steps, driving the datapath through one command bundle.
// ----------------------------------------------------------------------------
module vrra_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vrra_pkg::dp_stat_t   stat,
    output vrra_pkg::dp_cmd_t    cmd
);

    vrra_pkg::state_t state_reg;
    vrra_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vrra_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            vrra_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = vrra_pkg::ST_DISPATCH;
                end
            end
            vrra_pkg::ST_DISPATCH: begin
                unique case (stat.cmd) inside
                    vrra_pkg::CMD_RESERVE: begin
                        cmd.div_src = vrra_pkg::DIV_T_LEN;
                        state_next  = vrra_pkg::ST_RSV_NEED;
                    end
                    vrra_pkg::CMD_COMMIT: begin
                        if (!stat.rsv) begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = vrra_pkg::STS_NOT_RSV;
                            state_next    = vrra_pkg::ST_RESP;
                        end else begin
                            cmd.div_src = vrra_pkg::DIV_WP;
                            state_next  = vrra_pkg::ST_CMT_RD;
                        end
                    end
                    vrra_pkg::CMD_PEEK, vrra_pkg::CMD_RELEASE: begin
                        if (stat.empty) begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = vrra_pkg::STS_EMPTY;
                            state_next    = vrra_pkg::ST_RESP;
                        end else begin
                            cmd.div_src = vrra_pkg::DIV_RP;
                            state_next  = vrra_pkg::ST_RD_RP;
                        end
                    end
                endcase
            end
            // reserve: footprint, then slot index of the write position
            vrra_pkg::ST_RSV_NEED: begin
                cmd.need_ld = 1'b1;
                cmd.div_src = vrra_pkg::DIV_WP;
                state_next  = vrra_pkg::ST_RSV_CHK;
            end
            vrra_pkg::ST_RSV_CHK: begin
                unique case (stat.rsv_out)
                    vrra_pkg::RO_BAD: begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = vrra_pkg::STS_BAD_LEN;
                        cmd.rsv_clr   = 1'b1;
                        state_next    = vrra_pkg::ST_RESP;
                    end
                    vrra_pkg::RO_NO_ROOM: begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = vrra_pkg::STS_NO_ROOM;
                        cmd.rsv_clr   = 1'b1;
                        state_next    = vrra_pkg::ST_RESP;
                    end
                    vrra_pkg::RO_HERE: begin
                        cmd.rsv_here = 1'b1;
                        state_next   = vrra_pkg::ST_RESP;
                    end
                    vrra_pkg::RO_WRAP: begin
                        cmd.rsv_wrap = 1'b1;
                        state_next   = vrra_pkg::ST_RSV_WR0;
                    end
                endcase
            end
            vrra_pkg::ST_RSV_WR0: begin
                cmd.rsv_wr0 = 1'b1;
                state_next  = vrra_pkg::ST_RESP;
            end
            // commit: read pending header, footprint, advance writer
            vrra_pkg::ST_CMT_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = vrra_pkg::ST_CMT_FP;
            end
            vrra_pkg::ST_CMT_FP: begin
                cmd.hdr_ld  = 1'b1;
                cmd.div_src = vrra_pkg::DIV_T_HDR;
                state_next  = vrra_pkg::ST_CMT_NEED;
            end
            vrra_pkg::ST_CMT_NEED: begin
                cmd.need_ld = 1'b1;
                state_next  = vrra_pkg::ST_CMT_UPD;
            end
            vrra_pkg::ST_CMT_UPD: begin
                cmd.wp_adv = 1'b1;
                state_next = vrra_pkg::ST_RESP;
            end
            // peek / release: read header at reader, follow wrap marker
            vrra_pkg::ST_RD_RP: begin
                cmd.rd_en  = 1'b1;
                state_next = vrra_pkg::ST_MARK;
            end
            vrra_pkg::ST_MARK: begin
                if (stat.marker) begin
                    cmd.rp_zero = 1'b1;
                    state_next  = vrra_pkg::ST_RD_ZERO;
                end else begin
                    cmd.hdr_ld  = 1'b1;
                    cmd.div_src = vrra_pkg::DIV_T_HDR;
                    state_next  = vrra_pkg::ST_REC_NEED;
                end
            end
            vrra_pkg::ST_RD_ZERO: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_zero = 1'b1;
                state_next  = vrra_pkg::ST_LAT_ZERO;
            end
            vrra_pkg::ST_LAT_ZERO: begin
                cmd.hdr_ld  = 1'b1;
                cmd.div_src = vrra_pkg::DIV_T_HDR;
                state_next  = vrra_pkg::ST_REC_NEED;
            end
            vrra_pkg::ST_REC_NEED: begin
                cmd.need_ld = 1'b1;
                state_next  = vrra_pkg::ST_REC_UPD;
            end
            vrra_pkg::ST_REC_UPD: begin
                cmd.rec_rep = 1'b1;
                cmd.rp_adv  = (stat.cmd == vrra_pkg::CMD_RELEASE);
                state_next  = vrra_pkg::ST_RESP;
            end
            // hand the result to the output register once it is free
            vrra_pkg::ST_RESP: begin
                if (stat.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = vrra_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== src/variable_record_ring_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_allocator_unit: variable-length record ring allocator
// Hands out payload offsets for length-prefixed, aligned records in a byte
// ring; keeps only the record headers. Reserve, commit, peek, release.
//
//   channel   dir   handshake          beat
//   s_        in    s_valid/s_ready    in_beat_t  {command, length}
//   m_        out   m_valid/m_ready    out_beat_t {status, offset, rec_length}
//
// One command at a time, walked through its steps by the sequencer:
//   reserve checks room and may wrap, commit reads the pending header and
//   advances the writer, peek/release may follow a wrap marker to the front.
// Reset is synchronous, active low; the header RAM is not cleared.
// The output register takes a result while the previous one is still held
// only once m_ready drains it; until then no new command is accepted.
// ----------------------------------------------------------------------------
module variable_record_ring_allocator_unit #(
    parameter int CAPACITY = 4096,
    parameter int ALIGN    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vrra_pkg::in_beat_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output vrra_pkg::out_beat_t   m_data
);

    vrra_pkg::dp_cmd_t  dp_cmd;
    vrra_pkg::dp_stat_t dp_stat;

    vrra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    vrra_dp #(
        .CAPACITY (CAPACITY),
        .ALIGN    (ALIGN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (dp_cmd),
        .stat    (dp_stat)
    );

endmodule

// ===== src/vrra_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_chk: port-level checks for the allocator
// Watches the two channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module vrra_chk (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  vrra_pkg::out_beat_t   m_data
);

    // reset empties the output register
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // failed commands carry no offset or length
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != vrra_pkg::STS_OK) |->
            (m_data.offset == '0) && (m_data.rec_length == '0))
        else $error("non-ok result with nonzero fields");

    // one command in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a command is in progress");

endmodule

bind variable_record_ring_allocator_unit vrra_chk u_vrra_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/variable_record_ring_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_allocator_unit_tb: self-checking bench for the ring
// allocator
// A directed table covers reset answers, length extremes, error codes, both
// wrap styles and the marker walk. Random reserve/commit/peek/release traffic
// follows, in alternating fill and drain phases, with noise beats mixed in.
// Result beats are compared to typed directed replies or an in-bench predictor.
// Both channels idle at random, and the result side holds off for long
// stretches so that the input side backs up.
// ----------------------------------------------------------------------------
module variable_record_ring_allocator_unit_tb;
    import vrra_pkg::*;

    localparam int CAPACITY  = 4096;
    localparam int ALIGN     = 8;
    localparam int SLOTS     = CAPACITY / ALIGN;
    localparam int N_RANDOM  = 1550;
    localparam int N_DIRECT  = 25;
    localparam int MAX_PRINT = 40;

    // One directed row; the typed reply is used only when has_reply is set
    typedef struct {
        cmd_t           cmd;
        logic [12:0]    len;
        bit             has_reply;
        status_t        sts;
        logic [11:0]    off;
        logic [12:0]    rlen;
    } dir_row_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    in_beat_t       s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    out_beat_t      m_data;

    // Predictor state
    int unsigned        wr_pos;
    int unsigned        rd_pos;
    logic [CNT_W-1:0]   rec_cnt;
    bit                 rsv_pending;
    logic [HDR_W-1:0]   hdr_mem   [SLOTS];
    bit                 hdr_valid [SLOTS];

    out_beat_t  alloc_replies_q [$];
    int         err_cnt;
    int         got_cnt;
    bit         tx_calm;

    dir_row_t dir_rows [N_DIRECT] = '{
        '{CMD_PEEK,    13'd0,    1'b1, STS_EMPTY,   12'd0, 13'd0},
        '{CMD_RELEASE, 13'd0,    1'b1, STS_EMPTY,   12'd0, 13'd0},
        '{CMD_COMMIT,  13'd0,    1'b1, STS_NOT_RSV, 12'd0, 13'd0},
        '{CMD_RESERVE, 13'd0,    1'b1, STS_BAD_LEN, 12'd0, 13'd0},
        '{CMD_RESERVE, 13'd4097, 1'b1, STS_BAD_LEN, 12'd0, 13'd0},
        '{CMD_RESERVE, 13'd8191, 1'b1, STS_BAD_LEN, 12'd0, 13'd0},
        // full-ring length still needs a header: never fits
        '{CMD_RESERVE, 13'd4096, 1'b1, STS_NO_ROOM, 12'd0, 13'd0},
        '{CMD_RESERVE, 13'd1,    1'b1, STS_OK,      12'd8, 13'd1},
        // replaces the pending reservation, fills the whole ring
        '{CMD_RESERVE, 13'd4088, 1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_COMMIT,  13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_RESERVE, 13'd1,    1'b1, STS_NO_ROOM, 12'd0, 13'd0},
        '{CMD_RELEASE, 13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        // writer at the very end: wraps without leaving a marker
        '{CMD_RESERVE, 13'd8,    1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_COMMIT,  13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        // reader at the very end follows the empty tail to the front
        '{CMD_PEEK,    13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_RELEASE, 13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_RESERVE, 13'd4000, 1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_COMMIT,  13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_RELEASE, 13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        // tail too short for the record: zero marker, wrap to the front
        '{CMD_RESERVE, 13'd100,  1'b0, STS_OK,      12'd0, 13'd0},
        // failed reserve drops the pending one
        '{CMD_RESERVE, 13'd0,    1'b1, STS_BAD_LEN, 12'd0, 13'd0},
        '{CMD_COMMIT,  13'd0,    1'b1, STS_NOT_RSV, 12'd0, 13'd0},
        '{CMD_RESERVE, 13'd100,  1'b0, STS_OK,      12'd0, 13'd0},
        '{CMD_COMMIT,  13'd0,    1'b0, STS_OK,      12'd0, 13'd0},
        // reader hits the zero marker and jumps to the front
        '{CMD_RELEASE, 13'd0,    1'b0, STS_OK,      12'd0, 13'd0}
    };

    variable_record_ring_allocator_unit #(
        .CAPACITY (CAPACITY),
        .ALIGN    (ALIGN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Allocator predictor
    // ------------------------------------------------------------------
    function automatic int unsigned footprint(input int unsigned len);
        return ((len + HEADER + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    function automatic int unsigned hdr_get(input int unsigned pos);
        if (pos / ALIGN >= SLOTS) return 0;
        return hdr_mem[pos / ALIGN];
    endfunction

    function automatic void hdr_put(input int unsigned pos, input int unsigned val);
        if (pos / ALIGN < SLOTS) begin
            hdr_mem[pos / ALIGN]   = HDR_W'(val);
            hdr_valid[pos / ALIGN] = 1'b1;
        end
    endfunction

    function automatic out_beat_t alloc_step(input in_beat_t b);
        out_beat_t      r;
        int unsigned    len;
        int unsigned    need;
        int unsigned    l;
        r = '0;
        r.status = STS_OK;
        len = b.length;
        case (b.command)
            CMD_RESERVE: begin
                need = footprint(len);
                if (len == 0 || len > CAPACITY) begin
                    r.status = STS_BAD_LEN;
                end else if (wr_pos == rd_pos && rec_cnt != 0) begin
                    r.status = STS_NO_ROOM;
                end else if (wr_pos < rd_pos) begin
                    if (rd_pos - wr_pos < need) r.status = STS_NO_ROOM;
                end else if (wr_pos > CAPACITY || CAPACITY - wr_pos < need) begin
                    // does not fit before the end: wrap if the front has room
                    if (rd_pos < need) begin
                        r.status = STS_NO_ROOM;
                    end else begin
                        if (wr_pos <= CAPACITY && CAPACITY - wr_pos >= HEADER)
                            hdr_put(wr_pos, 0);
                        wr_pos = 0;
                    end
                end
                if (r.status == STS_OK) begin
                    hdr_put(wr_pos, len);
                    rsv_pending  = 1'b1;
                    r.offset     = OFF_W'(wr_pos + HEADER);
                    r.rec_length = LEN_W'(len);
                end else begin
                    rsv_pending = 1'b0;
                end
            end
            CMD_COMMIT: begin
                if (!rsv_pending) begin
                    r.status = STS_NOT_RSV;
                end else begin
                    l = hdr_get(wr_pos);
                    r.offset     = OFF_W'(wr_pos + HEADER);
                    r.rec_length = LEN_W'(l);
                    wr_pos      = (wr_pos + footprint(l)) % (1 << POS_W);
                    rec_cnt     = rec_cnt + 1'b1;
                    rsv_pending = 1'b0;
                end
            end
            default: begin
                if (rec_cnt == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    // short tail or zero marker sends the reader to the front
                    if (rd_pos > CAPACITY || CAPACITY - rd_pos < HEADER ||
                        hdr_get(rd_pos) == 0)
                        rd_pos = 0;
                    l = hdr_get(rd_pos);
                    r.offset     = OFF_W'(rd_pos + HEADER);
                    r.rec_length = LEN_W'(l);
                    if (b.command == CMD_RELEASE) begin
                        rd_pos  = (rd_pos + footprint(l)) % (1 << POS_W);
                        rec_cnt = rec_cnt - 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly small records, some large, a few out of range
    function automatic logic [12:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 13'($urandom_range(1, 200));
        if (r < 88) return 13'($urandom_range(201, 1000));
        if (r < 96) return 13'($urandom_range(1001, CAPACITY));
        if (r < 98) return 13'd0;
        return 13'($urandom_range(CAPACITY + 1, 8191));
    endfunction

    // Queue the expected reply, then present the beat until it is taken
    task automatic offer_cmd(input in_beat_t b, input out_beat_t typed, input bit use_typed);
        out_beat_t  pred;
        int         gap;
        pred = alloc_step(b);
        alloc_replies_q.push_back(use_typed ? typed : pred);
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
        err_cnt++;
        if (err_cnt <= MAX_PRINT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        in_beat_t       b;
        out_beat_t      typed;
        int             n_sent;
        int             r;
        int             rsv_pct;
        int unsigned    p;
        bit             unsafe;
        bit             owe_commit;
        wr_pos      = 0;
        rd_pos      = 0;
        rec_cnt     = '0;
        rsv_pending = 1'b0;
        err_cnt     = 0;
        tx_calm     = 1'b0;
        owe_commit  = 1'b0;
        foreach (hdr_valid[i]) hdr_valid[i] = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECT; i++) begin
            b.command        = dir_rows[i].cmd;
            b.length         = dir_rows[i].len;
            typed.status     = dir_rows[i].sts;
            typed.offset     = dir_rows[i].off;
            typed.rec_length = dir_rows[i].rlen;
            offer_cmd(b, typed, dir_rows[i].has_reply);
        end

        // random traffic: alternating fill and drain phases
        typed = '0;
        for (n_sent = 0; n_sent < N_RANDOM; n_sent++) begin
            if (n_sent % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            rsv_pct = ((n_sent / 120) % 2 == 0) ? 55 : 25;
            if (owe_commit) begin
                // now and then a second reserve replaces the pending one
                b.command  = ($urandom_range(0, 9) == 0) ? CMD_RESERVE : CMD_COMMIT;
                owe_commit = (b.command == CMD_RESERVE);
            end else begin
                r = $urandom_range(0, 99);
                if (r < rsv_pct) begin
                    b.command  = CMD_RESERVE;
                    owe_commit = 1'b1;
                end else if (r < rsv_pct + 10) begin
                    b.command = CMD_PEEK;
                end else if (r < 92) begin
                    b.command = CMD_RELEASE;
                end else begin
                    b.command = cmd_t'($urandom_range(0, 3));
                end
            end
            b.length = (b.command == CMD_RESERVE) ? pick_len() : 13'($urandom_range(0, 8191));

            // never let the reader land on a header slot that was never written
            if ((b.command == CMD_PEEK || b.command == CMD_RELEASE) && rec_cnt != 0) begin
                p = rd_pos;
                unsafe = 1'b0;
                if (p <= CAPACITY && CAPACITY - p >= HEADER) begin
                    if (!hdr_valid[p / ALIGN]) unsafe = 1'b1;
                    else if (hdr_mem[p / ALIGN] == 0) p = 0;
                end else begin
                    p = 0;
                end
                if (unsafe || !hdr_valid[p / ALIGN]) begin
                    b.command = CMD_RESERVE;
                    b.length  = pick_len();
                end
            end
            offer_cmd(b, typed, 1'b0);
        end
        s_valid <= 1'b0;

        // drain, then watch a little longer for stray beats
        while (alloc_replies_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-offs, reply checks
    // ------------------------------------------------------------------
    initial begin
        out_beat_t  exp_b;
        int         stall_left;
        int         hold_left;
        int         next_hold_at;
        int         cyc;
        bit         rx_calm;
        got_cnt      = 0;
        stall_left   = 0;
        hold_left    = 0;
        next_hold_at = 300;
        cyc          = 0;
        rx_calm      = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (aresetn && m_valid && m_ready) begin
                got_cnt++;
                if (alloc_replies_q.size() == 0) begin
                    flag_mismatch("unexpected result beat, status", -1, m_data.status);
                end else begin
                    exp_b = alloc_replies_q.pop_front();
                    if (m_data.status !== exp_b.status)
                        flag_mismatch("status", exp_b.status, m_data.status);
                    if (m_data.offset !== exp_b.offset)
                        flag_mismatch("offset", exp_b.offset, m_data.offset);
                    if (m_data.rec_length !== exp_b.rec_length)
                        flag_mismatch("rec_length", exp_b.rec_length, m_data.rec_length);
                end
            end
            if (cyc % 200 == 0) rx_calm = ($urandom_range(0, 2) == 0);
            // long hold-off so the input side fills up and stalls
            if (got_cnt >= next_hold_at) begin
                hold_left    = 400;
                next_hold_at = next_hold_at + 700;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
src/vrra_pkg.sv
src/vrra_adiv.sv
src/vrra_dp.sv
src/vrra_ctrl.sv
src/variable_record_ring_allocator_unit.sv
src/vrra_chk.sv
tb/sv/variable_record_ring_allocator_unit_tb.sv
